// File: design/sfg_pkg.sv
package sfg_pkg;

  // Scan store geometry and result limit
  localparam int SCAN_POINTS = 360;
  localparam int MAX_GAPS    = 64;
  localparam int ADDR_W      = $clog2(SCAN_POINTS);

  // Field widths
  localparam int IDX_W     = 9;
  localparam int RANGE_W   = 16;
  localparam int CHORD_W   = 17;
  localparam int LOOP_W    = IDX_W + 1;
  localparam int THR_W     = RANGE_W + 1;
  localparam int CNT_W     = $clog2(MAX_GAPS + 1);
  localparam int CFG_IDX_W = 3;

  // Restoring steps to fold a LOOP_W-bit index into the store
  localparam int MOD_STEPS = LOOP_W - ADDR_W + 1;

  // Half-angle sine table, Q0.15, one entry per degree of full span
  localparam int SINE_W      = 15;
  localparam int DEG_FULL    = 360;
  localparam int DEG_HALF    = 180;
  localparam int SINE_IDX_W  = $clog2(DEG_HALF + 1);
  localparam int CHORD_SHIFT = 14;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_INDEX = 3'd0,
    REG_FINAL_INDEX = 3'd1,
    REG_RADIUS_MIN  = 3'd2,
    REG_RADIUS_MAX  = 3'd3,
    REG_RADIUS_STEP = 3'd4,
    REG_MIN_WIDTH   = 3'd5,
    REG_MIN_SPAN    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   final_index;
    logic [RANGE_W-1:0] radius_min;
    logic [RANGE_W-1:0] radius_max;
    logic [RANGE_W-1:0] radius_step;
    logic [RANGE_W-1:0] min_width;
    logic [IDX_W-1:0]   min_span;
  } cfg_t;

  typedef struct packed {
    logic               gap_valid;
    logic [IDX_W-1:0]   gap_first;
    logic [IDX_W-1:0]   gap_final;
    logic [IDX_W-1:0]   gap_centre;
    logic [RANGE_W-1:0] gap_radius;
    logic [CHORD_W-1:0] gap_chord;
    logic               overflowed;
    logic               last_result;
  } gap_t;

  typedef logic [SINE_W-1:0] sine_tab_t [0:DEG_HALF];

  // Build the sine table at elaboration from a six-term series in Q30
  function automatic sine_tab_t sine_table_build();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    for (int k = 0; k <= DEG_HALF; k++) begin
      x    = (64'(k) * PI_Q30) / 64'(DEG_FULL);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      q    = (sum + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[k] = q[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = sine_table_build();

  // Fold an index below 2**LOOP_W into the store address range
  function automatic logic [ADDR_W-1:0] wrap_index(input logic [LOOP_W-1:0] v);
    logic [31:0] rem;
    rem = 32'(v);
    for (int s = MOD_STEPS - 1; s >= 0; s--) begin
      if (rem >= (32'(SCAN_POINTS) << s)) begin
        rem = rem - (32'(SCAN_POINTS) << s);
      end
    end
    return rem[ADDR_W-1:0];
  endfunction

endpackage

// File: design/sfg_ram.sv
module sfg_ram #(
  parameter int  DEPTH = 360,
  parameter int  WIDTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/sfg_chord.sv
module sfg_chord (
  input  logic                          clk,
  input  logic [sfg_pkg::IDX_W-1:0]     span,
  input  logic [sfg_pkg::RANGE_W-1:0]   range_in,
  output logic [sfg_pkg::CHORD_W-1:0]   chord
);

  import sfg_pkg::*;

  logic [IDX_W-1:0]          k_fold;
  logic [SINE_W-1:0]         sine_sel;
  logic [SINE_W-1:0]         sine_q;
  logic [RANGE_W-1:0]        r_q;
  logic [RANGE_W+SINE_W-1:0] prod;

  // Mirror the half angle above ninety degrees; no chord past a full turn
  always_comb begin
    k_fold   = (span > IDX_W'(DEG_HALF)) ? IDX_W'(DEG_FULL) - span : span;
    sine_sel = (span > IDX_W'(DEG_FULL)) ? '0 : SINE_TABLE[k_fold[SINE_IDX_W-1:0]];
  end

  // Table stage, then multiply stage
  always_ff @(posedge clk) begin
    sine_q <= sine_sel;
    r_q    <= range_in;
    prod   <= r_q * sine_q;
  end

  assign chord = prod[CHORD_SHIFT +: CHORD_W];

endmodule

// File: design/sfg_sweep.sv
module sfg_sweep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  sfg_pkg::cfg_t                 cfg,
  output logic [sfg_pkg::ADDR_W-1:0]    rd_addr,
  input  logic [sfg_pkg::RANGE_W-1:0]   rd_data,
  input  logic                          out_free,
  output logic                          push,
  output sfg_pkg::gap_t                 push_data,
  output logic                          busy
);

  import sfg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_THR,
    S_PRIME,
    S_SCAN,
    S_CHORD_A,
    S_CHORD_B,
    S_TEST,
    S_FINISH
  } state_t;

  state_t             state;
  logic [THR_W-1:0]   thr;
  logic [LOOP_W-1:0]  idx;
  logic [RANGE_W-1:0] prv;
  logic [RANGE_W-1:0] cur;
  logic [IDX_W-1:0]   run_start;
  logic [IDX_W-1:0]   span_q;
  logic [RANGE_W-1:0] r_q;
  logic [CNT_W-1:0]   count;
  logic               over;
  logic               pend_valid;
  gap_t               pend;

  logic [RANGE_W-1:0] step_eff;
  logic [THR_W-1:0]   thr_next;
  logic               above;
  logic               at_first;
  logic               at_final;
  logic               prev_low;
  logic               next_low;
  logic [IDX_W-1:0]   rs_eff;
  logic               run_end;
  logic [IDX_W-1:0]   span_now;
  logic [RANGE_W-1:0] r_now;
  logic [CHORD_W-1:0] chord;
  logic               gap_hit;
  logic               room;
  logic               blocked;
  logic               take;
  logic               adv;
  logic [LOOP_W-1:0]  rd_idx;
  gap_t               new_gap;

  sfg_chord u_chord (
    .clk      (clk),
    .span     (span_q),
    .range_in (r_q),
    .chord    (chord)
  );

  // Window decode: prv = R(i-1), cur = R(i), rd_data = R(i+1)
  always_comb begin
    step_eff = (cfg.radius_step == '0) ? RANGE_W'(1) : cfg.radius_step;
    thr_next = thr + THR_W'(step_eff);
    above    = THR_W'(cur) > thr;
    at_first = idx == LOOP_W'(cfg.first_index);
    at_final = idx == LOOP_W'(cfg.final_index);
    prev_low = THR_W'(prv) < thr;
    next_low = THR_W'(rd_data) < thr;
    rs_eff   = prev_low ? idx[IDX_W-1:0] : run_start;
    run_end  = above && !at_first && (at_final || next_low) &&
               (LOOP_W'(rs_eff) <= idx);
    span_now = IDX_W'(idx - LOOP_W'(rs_eff));
    r_now    = (rd_data < prv) ? rd_data : prv;
  end

  // Gap test and emit decision
  always_comb begin
    gap_hit = (span_q > cfg.min_span) && (chord > CHORD_W'(cfg.min_width));
    room    = count < CNT_W'(MAX_GAPS);
    blocked = pend_valid && !out_free;
    take    = (state == S_TEST) && gap_hit && room && !blocked;
    adv     = ((state == S_SCAN) && !run_end) ||
              ((state == S_TEST) && (!gap_hit || take));
  end

  // Read address: first index on a new threshold, else one or two ahead
  always_comb begin
    case (state)
      S_THR:   rd_idx = LOOP_W'(cfg.first_index);
      default: rd_idx = adv ? idx + LOOP_W'(2) : idx + LOOP_W'(1);
    endcase
    rd_addr = wrap_index(rd_idx);
  end

  // Build the gap just found and the beat handed to the output stage
  always_comb begin
    new_gap             = '0;
    new_gap.gap_valid   = 1'b1;
    new_gap.gap_first   = run_start;
    new_gap.gap_final   = idx[IDX_W-1:0];
    new_gap.gap_centre  = IDX_W'((LOOP_W'(run_start) + LOOP_W'(idx[IDX_W-1:0])) >> 1);
    new_gap.gap_radius  = thr[RANGE_W-1:0];
    new_gap.gap_chord   = chord;

    push      = 1'b0;
    push_data = pend;
    if (state == S_TEST) begin
      push = take && pend_valid;
    end else if (state == S_FINISH) begin
      push = out_free;
      if (pend_valid) begin
        push_data.overflowed = over;
      end else begin
        push_data = '0;
      end
      push_data.last_result = 1'b1;
    end
  end

  assign busy = state != S_IDLE;

  // Sweep sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      thr        <= '0;
      run_start  <= '0;
      count      <= '0;
      over       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            thr        <= THR_W'(cfg.radius_min);
            count      <= '0;
            over       <= 1'b0;
            pend_valid <= 1'b0;
            state      <= S_THR;
          end
        end
        S_THR: begin
          if (thr < THR_W'(cfg.radius_max)) begin
            if (cfg.first_index > cfg.final_index) begin
              thr <= thr_next;
            end else begin
              idx   <= LOOP_W'(cfg.first_index);
              state <= S_PRIME;
            end
          end else begin
            state <= S_FINISH;
          end
        end
        S_PRIME: begin
          cur   <= rd_data;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (above && (at_first || prev_low)) begin
            run_start <= idx[IDX_W-1:0];
          end
          if (run_end) begin
            span_q <= span_now;
            r_q    <= r_now;
            state  <= S_CHORD_A;
          end
        end
        S_CHORD_A: state <= S_CHORD_B;
        S_CHORD_B: state <= S_TEST;
        S_TEST: begin
          if (gap_hit && !room) begin
            over  <= 1'b1;
            state <= S_FINISH;
          end else if (take) begin
            pend       <= new_gap;
            pend_valid <= 1'b1;
            count      <= count + CNT_W'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Advance the window, or close this threshold at the last index
      if (adv) begin
        if (at_final) begin
          thr   <= thr_next;
          state <= S_THR;
        end else begin
          idx   <= idx + LOOP_W'(1);
          prv   <= cur;
          cur   <= rd_data;
          state <= S_SCAN;
        end
      end
    end
  end

endmodule

// File: design/scan_free_gap_finder_core.sv
// Free-gap finder over one range scan.
//
// Input channel (item_valid / item_stall): one beat per range sample,
// stored at the next scan index. The beat with end_of_scan set stores its
// sample, rewinds the write index and starts the sweep; item_stall stays
// high until the sweep has handed over its last result, so the next scan
// may start while that result still waits. Per threshold, S_THR and S_PRIME
// prime the sample window, the searched indices follow (one read of the
// range store per cycle) and each run end passes S_CHORD_A, S_CHORD_B and
// S_TEST; an empty index range only steps the threshold. The last threshold
// check and the hand-over of the final beat end the sweep. Result channel
// (result_valid / result_stall): one registered beat per gap, in the order
// found, the last one marked by last_result; a scan with no gap gives one
// beat with gap_valid low. Each gap is released when the next is found or
// the sweep ends, so the first beat leaves at the second gap or the sweep
// end. While the receiver stalls, the sweep holds at the next gap to hand
// over. Reset (rst, synchronous) empties the output stage, returns the
// sweep to idle and loads the registers' defaults; the range store is not
// cleared. The user writes the registers through cfg_write, cfg_index and
// cfg_data while idle; the block does not enforce this.
module scan_free_gap_finder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [sfg_pkg::RANGE_W-1:0]     sample_range,
  input  logic                            end_of_scan,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            gap_valid,
  output logic [sfg_pkg::IDX_W-1:0]       gap_first,
  output logic [sfg_pkg::IDX_W-1:0]       gap_final,
  output logic [sfg_pkg::IDX_W-1:0]       gap_centre,
  output logic [sfg_pkg::RANGE_W-1:0]     gap_radius,
  output logic [sfg_pkg::CHORD_W-1:0]     gap_chord,
  output logic                            overflowed,
  output logic                            last_result,
  input  logic                            cfg_write,
  input  logic [sfg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfg_pkg::RANGE_W-1:0]     cfg_data
);

  import sfg_pkg::*;

  cfg_t               cfg;
  logic [ADDR_W-1:0]  write_index;
  logic               accept;
  logic               busy;
  logic [ADDR_W-1:0]  rd_addr;
  logic [RANGE_W-1:0] rd_data;
  logic               out_free;
  logic               push;
  gap_t               push_data;
  gap_t               result_q;

  assign accept     = item_valid && !item_stall;
  assign item_stall = busy;
  assign out_free   = !result_valid || !result_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_index <= IDX_W'(0);
      cfg.final_index <= IDX_W'(179);
      cfg.radius_min  <= RANGE_W'(100);
      cfg.radius_max  <= RANGE_W'(1000);
      cfg.radius_step <= RANGE_W'(50);
      cfg.min_width   <= RANGE_W'(200);
      cfg.min_span    <= IDX_W'(8);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIRST_INDEX: cfg.first_index <= cfg_data[IDX_W-1:0];
        REG_FINAL_INDEX: cfg.final_index <= cfg_data[IDX_W-1:0];
        REG_RADIUS_MIN:  cfg.radius_min  <= cfg_data;
        REG_RADIUS_MAX:  cfg.radius_max  <= cfg_data;
        REG_RADIUS_STEP: cfg.radius_step <= cfg_data;
        REG_MIN_WIDTH:   cfg.min_width   <= cfg_data;
        REG_MIN_SPAN:    cfg.min_span    <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the write index; rewind on the end-of-scan beat
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
    end else if (accept) begin
      if (end_of_scan || (write_index == ADDR_W'(SCAN_POINTS - 1))) begin
        write_index <= '0;
      end else begin
        write_index <= write_index + ADDR_W'(1);
      end
    end
  end

  sfg_ram #(
    .DEPTH (SCAN_POINTS),
    .WIDTH (RANGE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (write_index),
    .wr_data (sample_range),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfg_sweep u_sweep (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && end_of_scan),
    .cfg       (cfg),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_free  (out_free),
    .push      (push),
    .push_data (push_data),
    .busy      (busy)
  );

  // Output stage: load a beat when free, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result_q <= push_data;
    end
  end

  assign gap_valid   = result_q.gap_valid;
  assign gap_first   = result_q.gap_first;
  assign gap_final   = result_q.gap_final;
  assign gap_centre  = result_q.gap_centre;
  assign gap_radius  = result_q.gap_radius;
  assign gap_chord   = result_q.gap_chord;
  assign overflowed  = result_q.overflowed;
  assign last_result = result_q.last_result;

endmodule

// File: bench/tb_scan_free_gap_finder_core.sv
`timescale 1ns / 1ps

module tb_scan_free_gap_finder_core;
  import sfg_pkg::*;

  localparam longint unsigned PI_SCALED_Q30 = 64'd3373259426;
  localparam int SETTLE_CYCLES = 16;
  localparam int END_CYCLES    = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 20000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic [RANGE_W-1:0]   sample_range = '0;
  logic                 end_of_scan = 1'b0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 gap_valid;
  logic [IDX_W-1:0]     gap_first;
  logic [IDX_W-1:0]     gap_final;
  logic [IDX_W-1:0]     gap_centre;
  logic [RANGE_W-1:0]   gap_radius;
  logic [CHORD_W-1:0]   gap_chord;
  logic                 overflowed;
  logic                 last_result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RANGE_W-1:0]   cfg_data = '0;

  // Mirror of the block: range store, write pointer, open run, registers
  logic [RANGE_W-1:0] range_mem [SCAN_POINTS];
  int unsigned        half_angle_sine [DEG_HALF + 1];
  int unsigned        wr_ptr = 0;
  int unsigned        run_begin = 0;
  int unsigned        cfg_first = 0;
  int unsigned        cfg_final = 179;
  int unsigned        cfg_rmin = 100;
  int unsigned        cfg_rmax = 1000;
  int unsigned        cfg_step = 50;
  int unsigned        cfg_width = 200;
  int unsigned        cfg_span = 8;

  // Pending gaps: newest enter at the front, the oldest leaves at the back
  gap_t gaps_due [$];
  int   mismatches = 0;
  int   gaps_checked = 0;
  int   items_sent = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  scan_free_gap_finder_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .sample_range (sample_range),
    .end_of_scan  (end_of_scan),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .gap_valid    (gap_valid),
    .gap_first    (gap_first),
    .gap_final    (gap_final),
    .gap_centre   (gap_centre),
    .gap_radius   (gap_radius),
    .gap_chord    (gap_chord),
    .overflowed   (overflowed),
    .last_result  (last_result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Fill the Q0.15 half-angle sine table from a six-term Taylor series
  function automatic void build_sine_table();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned q;
    longint unsigned div;
    for (int k = 0; k <= DEG_HALF; k++) begin
      x = (64'(k) * PI_SCALED_Q30) / 64'(DEG_FULL);
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 5; n++) begin
        div = 64'((2 * n) * (2 * n + 1));
        term = ((term * x2) >> 30) / div;
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      q = (acc + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      half_angle_sine[k] = 32'(q);
    end
  endfunction

  function automatic int unsigned range_at(int unsigned idx);
    return 32'(range_mem[idx % SCAN_POINTS]);
  endfunction

  // Store one sample; on end of scan sweep the thresholds and queue the gaps
  function automatic void predict_gaps(logic [RANGE_W-1:0] r_cm, logic eos);
    gap_t        found [MAX_GAPS];
    int unsigned n_found;
    gap_t        g;
    int unsigned thr;
    int unsigned step;
    int unsigned a;
    int unsigned b;
    int unsigned nb;
    int unsigned span;
    int unsigned half;
    int unsigned chord;
    int unsigned mid;
    bit          over;
    range_mem[wr_ptr] = r_cm;
    wr_ptr = (wr_ptr + 1) % SCAN_POINTS;
    if (!eos) begin
      return;
    end
    wr_ptr = 0;
    over = 1'b0;
    n_found = 0;
    step = (cfg_step == 0) ? 1 : cfg_step;
    thr = cfg_rmin;
    while (thr < cfg_rmax && !over) begin
      for (int unsigned i = cfg_first; i <= cfg_final && !over; i++) begin
        if (range_at(i) > thr) begin
          if (i == cfg_first) begin
            // a run at the first index only opens there
            run_begin = i;
          end else begin
            if (range_at(i - 1) < thr) begin
              run_begin = i;
            end
            // close the run unless its start is stale
            if ((i == cfg_final || range_at(i + 1) < thr) && run_begin <= i) begin
              a = range_at(i + 1);
              b = range_at(i - 1);
              nb = (a < b) ? a : b;
              span = i - run_begin;
              half = (span > DEG_HALF) ? DEG_FULL - span : span;
              chord = 32'((64'(nb) * 64'(half_angle_sine[half])) >> CHORD_SHIFT);
              if (span > cfg_span && chord > cfg_width) begin
                if (n_found >= MAX_GAPS) begin
                  over = 1'b1;
                end else begin
                  mid = (run_begin + i) >> 1;
                  g = '0;
                  g.gap_valid = 1'b1;
                  g.gap_first = run_begin[IDX_W-1:0];
                  g.gap_final = i[IDX_W-1:0];
                  g.gap_centre = mid[IDX_W-1:0];
                  g.gap_radius = thr[RANGE_W-1:0];
                  g.gap_chord = chord[CHORD_W-1:0];
                  found[n_found] = g;
                  n_found++;
                end
              end
            end
          end
        end
      end
      thr = thr + step;
    end
    // mark the last beat of the scan, or give the empty one
    if (n_found == 0) begin
      g = '0;
      g.last_result = 1'b1;
      gaps_due.push_front(g);
    end else begin
      found[n_found - 1].overflowed = over;
      found[n_found - 1].last_result = 1'b1;
      for (int unsigned k = 0; k < n_found; k++) begin
        gaps_due.push_front(found[k]);
      end
    end
  endfunction

  // Offer one sample beat after a random gap and hold it until taken
  task automatic send_sample(input logic [RANGE_W-1:0] r_cm, input logic eos);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    sample_range <= r_cm;
    end_of_scan <= eos;
    @(posedge clk);
    while (item_stall) begin
      @(posedge clk);
    end
    items_sent++;
    predict_gaps(r_cm, eos);
  endtask

  task automatic write_reg(input cfg_reg_t which, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data <= value[RANGE_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (which)
      REG_FIRST_INDEX: cfg_first = value & 32'h1FF;
      REG_FINAL_INDEX: cfg_final = value & 32'h1FF;
      REG_RADIUS_MIN:  cfg_rmin = value & 32'hFFFF;
      REG_RADIUS_MAX:  cfg_rmax = value & 32'hFFFF;
      REG_RADIUS_STEP: cfg_step = value & 32'hFFFF;
      REG_MIN_WIDTH:   cfg_width = value & 32'hFFFF;
      REG_MIN_SPAN:    cfg_span = value & 32'h1FF;
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned first, input int unsigned final_i,
                            input int unsigned rmin, input int unsigned rmax,
                            input int unsigned step, input int unsigned width,
                            input int unsigned span);
    write_reg(REG_FIRST_INDEX, first);
    write_reg(REG_FINAL_INDEX, final_i);
    write_reg(REG_RADIUS_MIN, rmin);
    write_reg(REG_RADIUS_MAX, rmax);
    write_reg(REG_RADIUS_STEP, step);
    write_reg(REG_MIN_WIDTH, width);
    write_reg(REG_MIN_SPAN, span);
  endtask

  // Drop valid, wait for every pending gap, then let the sweep settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (gaps_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Empty search range: one sample, one empty last beat
  task automatic test_empty_range();
    wait_idle();
    set_config(5, 4, 100, 1000, 50, 200, 8);
    send_sample(16'hFFFF, 1'b1);
  endtask

  // Runs against thresholds: equal neighbours, stale start, final-index end
  task automatic test_run_edges();
    int unsigned pattern [12] = '{50, 200, 300, 0, 100, 400, 400, 200, 50, 1000,
                                  65535, 5000};
    wait_idle();
    set_config(0, 10, 100, 301, 100, 0, 0);
    for (int k = 0; k < 12; k++) begin
      send_sample(16'(pattern[k]), k == 11);
    end
  endtask

  // Zero step behaves as a step of one; run opens at the first index
  task automatic test_zero_step();
    wait_idle();
    set_config(0, 10, 100, 103, 0, 0, 0);
    send_sample(16'd500, 1'b1);
  endtask

  // Dense thresholds push past the gap limit
  task automatic test_overflow();
    wait_idle();
    set_config(0, 10, 0, 1000, 10, 0, 0);
    send_sample(16'hFFFF, 1'b1);
  endtask

  task automatic test_no_gap();
    wait_idle();
    set_config(0, 10, 100, 1000, 50, 65535, 0);
    send_sample(16'h0000, 1'b1);
  endtask

  // Whole store, write pointer wrap, neighbour past the last index
  task automatic test_full_scan();
    wait_idle();
    set_config(0, 359, 1000, 65535, 65535, 0, 0);
    for (int k = 0; k <= SCAN_POINTS; k++) begin
      send_sample(($urandom_range(4) < 2) ? 16'($urandom_range(999))
                                          : 16'($urandom_range(1000, 65535)),
                  k == SCAN_POINTS);
    end
    wait_idle();
    set_config(359, 359, 65535, 0, 65535, 65535, 359);
    send_sample(16'hFFFF, 1'b1);
    wait_idle();
    set_config(0, 0, 0, 65535, 65535, 0, 0);
    send_sample(16'h0000, 1'b1);
  endtask

  // Long receiver hold while the next scan is offered behind the sweep
  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    wait_idle();
    set_config(0, 30, 0, 1000, 50, 0, 0);
    for (int k = 0; k < 31; k++) begin
      send_sample((k % 4 == 0) ? 16'd400 : 16'd3000, 1'b0);
    end
    hold_req <= hold_req + 1;
    send_sample(16'd400, 1'b1);
    for (int k = 0; k < 8; k++) begin
      send_sample(16'($urandom_range(65535)), k == 7);
    end
    wait_idle();
  endtask

  // Random registers and scans across the idle and stall phases
  task automatic test_random_scans();
    int unsigned first;
    int unsigned final_i;
    int unsigned rmin;
    int unsigned rmax;
    int unsigned step;
    int unsigned st;
    int unsigned len;
    int unsigned sel;
    int unsigned v;
    int          phase_start;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
        default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < 50) begin
        wait_idle();
        first = ($urandom_range(3) == 0) ? $urandom_range(359) : $urandom_range(15);
        if ($urandom_range(7) == 0 && first != 0) begin
          final_i = $urandom_range(first - 1);
        end else begin
          final_i = first + $urandom_range(30);
          if (final_i > 359) begin
            final_i = 359;
          end
        end
        rmin = $urandom_range(1500);
        step = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 400);
        st = (step == 0) ? 1 : step;
        rmax = rmin + st * $urandom_range(12) + $urandom_range(2);
        if (rmax > 65535) begin
          rmax = 65535;
        end
        set_config(first, final_i, rmin, rmax, step,
                   ($urandom_range(3) == 0) ? 0 : $urandom_range(300), $urandom_range(10));
        repeat ($urandom_range(1, 2)) begin
          len = (final_i + 2 <= 30 && $urandom_range(3) != 0)
              ? $urandom_range(final_i + 2, 30) : $urandom_range(1, 30);
          for (int unsigned k = 0; k < len; k++) begin
            // mix noise, extremes, values below and right at the thresholds
            sel = $urandom_range(99);
            if (sel < 20) begin
              v = $urandom_range(65535);
            end else if (sel < 30) begin
              v = ($urandom_range(1) == 1) ? 65535 : 0;
            end else if (sel < 55) begin
              v = $urandom_range(rmin);
            end else begin
              v = rmin + st * $urandom_range(12) + $urandom_range(2);
              if (v > 0) begin
                v = v - 1;
              end
              if (v > 65535) begin
                v = 65535;
              end
            end
            send_sample(16'(v), k == len - 1);
          end
        end
      end
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  // Drive result stall: a requested long hold first, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Check each accepted result beat against the oldest pending gap
  always @(posedge clk) begin
    gap_t seen;
    gap_t want;
    if (!rst && result_valid && !result_stall) begin
      seen = {gap_valid, gap_first, gap_final, gap_centre, gap_radius, gap_chord,
              overflowed, last_result};
      gaps_checked++;
      if (gaps_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: valid=%0d first=%0d final=%0d radius=%0d last=%0d",
                   seen.gap_valid, seen.gap_first, seen.gap_final, seen.gap_radius,
                   seen.last_result);
        end
      end else begin
        want = gaps_due.pop_back();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("gap mismatch expected: valid=%0d first=%0d final=%0d centre=%0d %s",
                     want.gap_valid, want.gap_first, want.gap_final, want.gap_centre,
                     $sformatf("radius=%0d chord=%0d ovf=%0d last=%0d", want.gap_radius,
                               want.gap_chord, want.overflowed, want.last_result));
            $display("gap mismatch actual:   valid=%0d first=%0d final=%0d centre=%0d %s",
                     seen.gap_valid, seen.gap_first, seen.gap_final, seen.gap_centre,
                     $sformatf("radius=%0d chord=%0d ovf=%0d last=%0d", seen.gap_radius,
                               seen.gap_chord, seen.overflowed, seen.last_result));
          end
        end
      end
    end
  end

  // Abort when neither channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL scan_free_gap_finder_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    build_sine_table();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_range();
    test_run_edges();
    test_zero_step();
    test_overflow();
    test_no_gap();
    test_full_scan();
    test_backpressure();
    test_random_scans();
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && gaps_due.size() == 0) begin
      $display("PASS scan_free_gap_finder_core");
    end else begin
      $display("FAIL scan_free_gap_finder_core");
    end
    $finish;
  end

endmodule
